[hdl/lpfp_pkg.sv]
`default_nettype none

package lpfp_pkg;

	typedef enum logic [2:0] {
		PH_SIZE   = 3'd0,
		PH_EXSIZE = 3'd1,
		PH_ID     = 3'd2,
		PH_DATA   = 3'd3,
		PH_CCODE  = 3'd4,
		PH_CBODY  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		K_DHDR  = 3'd0,
		K_DBYTE = 3'd1,
		K_CHDR  = 3'd2,
		K_CBYTE = 3'd3,
		K_ERR   = 3'd4
	} kind_t;

	localparam logic [15:0] SIZE_ESCAPE = 16'hFFFF;
	localparam logic [2:0] EXSIZE_LAST = 3'd7;
	localparam logic [63:0] CODE_BYTES = 64'd4;

endpackage

`default_nettype wire

[hdl/length_prefixed_frame_parser.sv]
// channel   signals                                                 direction
// rx        rx_valid, rx_stall, rx_byte                             byte stream in
// res       res_valid, res_stall, kind .. last (seven fields)       results out
//
// one byte per cycle unless res_stall holds; a byte and then its result are registered
// the byte register in front of the parser lets a byte in while a result is held
// reset puts the parser in the size phase with all counters cleared
// rx_stall rises only when the byte register is full and the result register is stalled
`default_nettype none

module length_prefixed_frame_parser
	import lpfp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rx_valid,
	output logic                    rx_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [2:0]              kind,
	output logic [15:0]             message_id,
	output logic [63:0]             payload_size,
	output logic [7:0]              payload_byte,
	output logic [63:0]             byte_offset,
	output logic signed [31:0]      control_code,
	output logic                    last
);

	logic        valid_s1;
	logic [7:0]  byte_s1;

	phase_t      phase_q, phase_d;
	logic [2:0]  fbc_q, fbc_d;
	logic [63:0] size_q, size_d;
	logic [63:0] offset_q, offset_d;
	logic [15:0] id_q, id_d;
	logic [31:0] code_q, code_d;

	logic        res_valid_q;
	kind_t       kind_q, kind_d;
	logic [15:0] id_res_q, id_res_d;
	logic [63:0] size_res_q;
	logic [7:0]  byte_res_q, byte_res_d;
	logic [63:0] off_res_q, off_res_d;
	logic [31:0] code_res_q, code_res_d;
	logic        last_q, last_d;
	logic        emit_d;

	logic        advance;
	logic [63:0] offset_inc;
	logic [15:0] id_full;
	logic [31:0] code_new;
	logic [15:0] size_short;

	assign advance  = valid_s1 && (!res_valid_q || !res_stall);
	assign rx_stall = valid_s1 && !advance;

	assign offset_inc = offset_q + 64'd1;
	assign id_full    = {id_q[7:0], byte_s1};
	assign code_new   = {code_q[23:0], byte_s1};
	assign size_short = {size_q[7:0], byte_s1};

	// input byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		fbc_d      = fbc_q;
		size_d     = size_q;
		offset_d   = offset_q;
		id_d       = id_q;
		code_d     = code_q;
		emit_d     = 1'b0;
		kind_d     = K_ERR;
		id_res_d   = 16'd0;
		byte_res_d = 8'd0;
		off_res_d  = 64'd0;
		code_res_d = 32'd0;
		last_d     = 1'b0;
		case (phase_q)
			PH_EXSIZE: begin
				size_d = {size_q[55:0], byte_s1};
				if (fbc_q == EXSIZE_LAST) begin
					fbc_d   = 3'd0;
					phase_d = PH_ID;
				end else begin
					fbc_d = fbc_q + 3'd1;
				end
			end
			PH_ID: begin
				if (fbc_q == 3'd0) begin
					id_d  = {8'd0, byte_s1};
					fbc_d = 3'd1;
				end else begin
					id_d     = id_full;
					fbc_d    = 3'd0;
					offset_d = 64'd0;
					code_d   = 32'd0;
					if (id_full != 16'd0) begin
						emit_d   = 1'b1;
						kind_d   = K_DHDR;
						id_res_d = id_full;
						last_d   = (size_q == 64'd0);
						phase_d  = (size_q == 64'd0) ? PH_SIZE : PH_DATA;
					end else if (size_q == 64'd0) begin
						emit_d  = 1'b1;
						kind_d  = K_ERR;
						last_d  = 1'b1;
						phase_d = PH_SIZE;
					end else begin
						phase_d = PH_CCODE;
					end
				end
			end
			PH_DATA: begin
				emit_d     = 1'b1;
				kind_d     = K_DBYTE;
				id_res_d   = id_q;
				byte_res_d = byte_s1;
				off_res_d  = offset_q;
				last_d     = (offset_inc == size_q);
				offset_d   = offset_inc;
				if (offset_inc == size_q) begin
					phase_d = PH_SIZE;
				end
			end
			PH_CCODE: begin
				code_d   = code_new;
				offset_d = offset_inc;
				if (offset_inc >= CODE_BYTES) begin
					emit_d     = 1'b1;
					kind_d     = K_CHDR;
					code_res_d = code_new;
					last_d     = (size_q == CODE_BYTES);
					phase_d    = (size_q == CODE_BYTES) ? PH_SIZE : PH_CBODY;
				end else if (offset_inc == size_q) begin
					// control payload too short to hold its code
					emit_d  = 1'b1;
					kind_d  = K_ERR;
					last_d  = 1'b1;
					phase_d = PH_SIZE;
				end
			end
			PH_CBODY: begin
				emit_d     = 1'b1;
				kind_d     = K_CBYTE;
				byte_res_d = byte_s1;
				off_res_d  = offset_q;
				code_res_d = code_q;
				last_d     = (offset_inc == size_q);
				offset_d   = offset_inc;
				if (offset_inc == size_q) begin
					phase_d = PH_SIZE;
				end
			end
			default: begin
				phase_d = PH_SIZE;
				if (fbc_q == 3'd0) begin
					size_d = {56'd0, byte_s1};
					fbc_d  = 3'd1;
				end else begin
					fbc_d = 3'd0;
					if (size_short == SIZE_ESCAPE) begin
						size_d  = 64'd0;
						phase_d = PH_EXSIZE;
					end else begin
						size_d  = {48'd0, size_short};
						phase_d = PH_ID;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE;
			fbc_q       <= 3'd0;
			size_q      <= 64'd0;
			offset_q    <= 64'd0;
			id_q        <= 16'd0;
			code_q      <= 32'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q  <= phase_d;
				fbc_q    <= fbc_d;
				size_q   <= size_d;
				offset_q <= offset_d;
				id_q     <= id_d;
				code_q   <= code_d;
			end
			if (advance && emit_d) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && emit_d) begin
			kind_q     <= kind_d;
			id_res_q   <= id_res_d;
			size_res_q <= size_d;
			byte_res_q <= byte_res_d;
			off_res_q  <= off_res_d;
			code_res_q <= code_res_d;
			last_q     <= last_d;
		end
	end

	assign res_valid    = res_valid_q;
	assign kind         = kind_q;
	assign message_id   = id_res_q;
	assign payload_size = size_res_q;
	assign payload_byte = byte_res_q;
	assign byte_offset  = off_res_q;
	assign control_code = code_res_q;
	assign last         = last_q;

`ifndef ASSERT_OFF
	a_last_ends_message: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit_d && last_d) |=> (phase_q == PH_SIZE && fbc_q == 3'd0))
		else $error("message end did not return to size phase");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && kind_q == K_ERR) |-> (last_q && id_res_q == 16'd0))
		else $error("framing error result without last or with an id");

	a_data_has_id: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (id_q != 16'd0))
		else $error("data phase with zero message id");

	a_code_phase_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CCODE) |-> (id_q == 16'd0 && offset_q < CODE_BYTES))
		else $error("control code phase out of bounds");

	a_id_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ID || phase_q == PH_SIZE) |-> (fbc_q <= 3'd1))
		else $error("two-byte field count out of range");
`endif

endmodule

`default_nettype wire

[tb/sv/length_prefixed_frame_parser_test.sv]
import lpfp_pkg::*;

typedef struct packed {
	kind_t              kind;
	logic [15:0]        message_id;
	logic [63:0]        payload_size;
	logic [7:0]         payload_byte;
	logic [63:0]        byte_offset;
	logic signed [31:0] control_code;
	logic               last;
} frame_result_t;

// tracks the deframing state and the results still owed by the block
class frame_tracker;
	phase_t        phase;
	logic [2:0]    field_count;
	logic [63:0]   size_acc;
	logic [63:0]   offset;
	logic [15:0]   id;
	logic [31:0]   code;
	frame_result_t awaited_results[$];
	int            errors;
	int            checked;
	int            kind_seen[5];

	function new();
		phase = PH_SIZE;
		field_count = 3'd0;
		size_acc = 64'd0;
		offset = 64'd0;
		id = 16'd0;
		code = 32'd0;
		errors = 0;
		checked = 0;
		foreach (kind_seen[i]) kind_seen[i] = 0;
	endfunction

	function int pending();
		return awaited_results.size();
	endfunction

	function void expect_result(kind_t k, logic [15:0] mid, logic [7:0] pb,
			logic [63:0] off, logic [31:0] cc, logic lst);
		frame_result_t r;
		r.kind = k;
		r.message_id = mid;
		r.payload_size = size_acc;
		r.payload_byte = pb;
		r.byte_offset = off;
		r.control_code = cc;
		r.last = lst;
		awaited_results.push_back(r);
	endfunction

	// one accepted transaction on the byte channel
	function void take_byte(logic [7:0] b);
		logic lst;
		case (phase)
		PH_EXSIZE: begin
			size_acc = {size_acc[55:0], b};
			if (field_count >= EXSIZE_LAST) begin
				field_count = 3'd0;
				phase = PH_ID;
			end else begin
				field_count = field_count + 3'd1;
			end
		end
		PH_ID: begin
			if (field_count == 3'd0) begin
				id = {8'd0, b};
				field_count = 3'd1;
			end else begin
				id = {id[7:0], b};
				field_count = 3'd0;
				offset = 64'd0;
				code = 32'd0;
				if (id != 16'd0) begin
					lst = (size_acc == 64'd0);
					expect_result(K_DHDR, id, 8'd0, 64'd0, 32'd0, lst);
					phase = lst ? PH_SIZE : PH_DATA;
				end else if (size_acc == 64'd0) begin
					expect_result(K_ERR, 16'd0, 8'd0, 64'd0, 32'd0, 1'b1);
					phase = PH_SIZE;
				end else begin
					phase = PH_CCODE;
				end
			end
		end
		PH_DATA: begin
			lst = (offset + 64'd1 == size_acc);
			expect_result(K_DBYTE, id, b, offset, 32'd0, lst);
			offset = offset + 64'd1;
			if (lst) phase = PH_SIZE;
		end
		PH_CCODE: begin
			code = {code[23:0], b};
			offset = offset + 64'd1;
			if (offset >= CODE_BYTES) begin
				lst = (size_acc == CODE_BYTES);
				expect_result(K_CHDR, 16'd0, 8'd0, 64'd0, code, lst);
				phase = lst ? PH_SIZE : PH_CBODY;
			end else if (offset == size_acc) begin
				// control payload too short to hold its code
				expect_result(K_ERR, 16'd0, 8'd0, 64'd0, 32'd0, 1'b1);
				phase = PH_SIZE;
			end
		end
		PH_CBODY: begin
			lst = (offset + 64'd1 == size_acc);
			expect_result(K_CBYTE, 16'd0, b, offset, code, lst);
			offset = offset + 64'd1;
			if (lst) phase = PH_SIZE;
		end
		default: begin
			phase = PH_SIZE;
			if (field_count == 3'd0) begin
				size_acc = {56'd0, b};
				field_count = 3'd1;
			end else begin
				size_acc = {48'd0, size_acc[7:0], b};
				field_count = 3'd0;
				if (size_acc[15:0] == SIZE_ESCAPE) begin
					size_acc = 64'd0;
					phase = PH_EXSIZE;
				end else begin
					phase = PH_ID;
				end
			end
		end
		endcase
	endfunction

	function void compare(string field, logic [63:0] want, logic [63:0] seen);
		if (want !== seen) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, seen);
		end
	endfunction

	// one accepted transaction on the result channel
	function void check_result(frame_result_t got);
		frame_result_t want;
		if (awaited_results.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual kind %0d id %h",
				$time, got.kind, got.message_id);
			return;
		end
		want = awaited_results.pop_front();
		checked++;
		if (int'(want.kind) < 5) kind_seen[int'(want.kind)]++;
		compare("kind", 64'(want.kind), 64'(got.kind));
		compare("message_id", 64'(want.message_id), 64'(got.message_id));
		compare("payload_size", want.payload_size, got.payload_size);
		compare("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
		compare("byte_offset", want.byte_offset, got.byte_offset);
		compare("control_code", 64'($unsigned(want.control_code)),
			64'($unsigned(got.control_code)));
		compare("last", 64'(want.last), 64'(got.last));
	endfunction
endclass

module length_prefixed_frame_parser_test;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_STOP = 640;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic rx_stall;
	logic [7:0] rx_byte = 8'd0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [2:0] kind;
	logic [15:0] message_id;
	logic [63:0] payload_size;
	logic [7:0] payload_byte;
	logic [63:0] byte_offset;
	logic signed [31:0] control_code;
	logic last;

	frame_tracker frames;
	logic [7:0] tx_bytes[$];
	int bytes_sent = 0;
	int unsigned cycle_count = 0;
	bit sender_idle = 1'b1;
	bit sink_idle = 1'b1;
	bit hold_req = 1'b0;

	length_prefixed_frame_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind(kind),
		.message_id(message_id),
		.payload_size(payload_size),
		.payload_byte(payload_byte),
		.byte_offset(byte_offset),
		.control_code(control_code),
		.last(last)
	);

	always #4 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout after %0d cycles, %0d results outstanding",
			$time, cycle_count, frames.pending());
		$display("CHECKS FAILED");
		$finish;
	end

	// values read here are the ones the edge itself saw
	always @(posedge clk) begin
		frame_result_t got;
		if (arst_n) begin
			if (rx_valid && !rx_stall) frames.take_byte(rx_byte);
			if (res_valid && !res_stall) begin
				got.kind = kind_t'(kind);
				got.message_id = message_id;
				got.payload_size = payload_size;
				got.payload_byte = payload_byte;
				got.byte_offset = byte_offset;
				got.control_code = control_code;
				got.last = last;
				frames.check_result(got);
			end
		end
	end

	// result side: random stall bursts and one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
			end else if (sink_idle && $urandom_range(0, 4) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (sender_idle && $urandom_range(0, 3) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (rx_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_queued();
		while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
	endtask

	task automatic drain_results();
		rx_valid <= 1'b0;
		while (frames.pending() != 0) @(posedge clk);
	endtask

	task automatic put_size(input logic [63:0] size, input bit escaped);
		if (escaped || size >= 64'(SIZE_ESCAPE)) begin
			tx_bytes.push_back(8'hFF);
			tx_bytes.push_back(8'hFF);
			for (int i = 7; i >= 0; i--) tx_bytes.push_back(size[i*8 +: 8]);
		end else begin
			tx_bytes.push_back(size[15:8]);
			tx_bytes.push_back(size[7:0]);
		end
	endtask

	task automatic put_data(input logic [15:0] id, input logic [63:0] size, input bit escaped);
		put_size(size, escaped);
		tx_bytes.push_back(id[15:8]);
		tx_bytes.push_back(id[7:0]);
		for (int i = 0; i < int'(size); i++) tx_bytes.push_back(8'($urandom));
	endtask

	// size below 4 makes a short control message
	task automatic put_control(input logic [63:0] size, input logic [31:0] code,
			input bit escaped);
		put_size(size, escaped);
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'h00);
		for (int i = 0; i < int'(size); i++) begin
			if (i < 4) tx_bytes.push_back(code[31 - 8*i -: 8]);
			else tx_bytes.push_back(8'($urandom));
		end
	endtask

	initial begin
		int pick;
		logic [63:0] size;
		bit escaped;
		frames = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner messages
		put_data(16'hFFFF, 64'd0, 1'b0);
		put_control(64'd0, 32'd0, 1'b0);
		put_control(64'd3, 32'hA5C3_5A00, 1'b0);
		put_control(64'd4, 32'h8000_0000, 1'b0);
		put_control(64'd5, 32'h7FFF_FFFF, 1'b0);
		put_data(16'h0001, 64'd1, 1'b1);
		send_queued();
		drain_results();

		// long result hold-off while bytes keep coming
		sender_idle = 1'b0;
		sink_idle = 1'b0;
		hold_req = 1'b1;
		put_data(16'h8000, 64'd30, 1'b0);
		send_queued();

		while (bytes_sent < RANDOM_STOP) begin
			sender_idle = $urandom_range(0, 3) != 0;
			sink_idle = $urandom_range(0, 3) != 0;
			pick = $urandom_range(0, 99);
			escaped = $urandom_range(0, 9) == 0;
			if ($urandom_range(0, 9) < 8) size = 64'($urandom_range(0, 8));
			else size = 64'($urandom_range(9, 48));
			if (pick < 60) put_data(16'($urandom_range(1, 65535)), size, escaped);
			else if (pick < 88) put_control(64'($urandom_range(4, 16)), $urandom, escaped);
			else put_control(64'($urandom_range(0, 3)), $urandom, escaped);
			send_queued();
		end

		// back-to-back traffic with no idling at either end
		sender_idle = 1'b0;
		sink_idle = 1'b0;
		repeat (10) begin
			if ($urandom_range(0, 1) == 0)
				put_data(16'($urandom_range(1, 65535)), 64'($urandom_range(0, 8)), 1'b0);
			else
				put_control(64'($urandom_range(4, 10)), $urandom, 1'b0);
		end
		// an endless message carrying the largest size
		put_size(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		tx_bytes.push_back(8'h80);
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(8'h5A);
		tx_bytes.push_back(8'hA5);
		send_queued();
		drain_results();
		repeat (8) @(posedge clk);

		$display("run covered %0d stream bytes and %0d checked results", bytes_sent,
			frames.checked);
		$display("data headers %0d, data bytes %0d, control headers %0d, control bytes %0d, errors %0d",
			frames.kind_seen[0], frames.kind_seen[1], frames.kind_seen[2],
			frames.kind_seen[3], frames.kind_seen[4]);
		if (frames.errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
